@@ src/slbc_pkg.sv @@
package slbc_pkg;

  // status conditions, in the order of the result field code
  typedef enum logic [2:0] {
    COND_NET_DOWN    = 3'd0,
    COND_WAITING     = 3'd1,
    COND_LINKED      = 3'd2,
    COND_STANDALONE  = 3'd3,
    COND_SERVER_DOWN = 3'd4
  } cond_t;

  // brightness modes; the unused code acts as normal
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_DIM    = 2'd1;
  localparam logic [1:0] MODE_OFF    = 2'd2;

  // register map, byte addresses
  localparam int         ADDR_W          = 4;
  localparam logic [3:0] ADDR_BRIGHTNESS = 4'd0;
  localparam logic [3:0] ADDR_STANDALONE = 4'd4;
  localparam logic [3:0] ADDR_ALIVE      = 4'd8;

  localparam logic [31:0] ALIVE_RESET = 32'd3000;

  // dimming is x*77/255, only ever applied to the fixed palette values
  localparam int DIM_NUM = 77;
  localparam int DIM_DEN = 255;
  localparam logic [7:0] DIM_255 = 8'(255 * DIM_NUM / DIM_DEN);
  localparam logic [7:0] DIM_200 = 8'(200 * DIM_NUM / DIM_DEN);
  localparam logic [7:0] DIM_120 = 8'(120 * DIM_NUM / DIM_DEN);

  localparam int PERIOD_W = 10;

  typedef struct packed {
    logic [7:0]          r;
    logic [7:0]          g;
    logic [7:0]          b;
    logic [7:0]          dr;
    logic [7:0]          dg;
    logic [7:0]          db;
    logic [PERIOD_W-1:0] period;
  } look_t;

  typedef struct packed {
    logic [31:0] time_ms;
    logic        network_up;
    logic        server_ok;
    logic [31:0] last_packet_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    cond_t      condition;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  brightness_mode;
    logic        standalone_role;
    logic [31:0] alive_window_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] last_flip_ms;
    logic        blink_phase;
  } blink_state_t;

  // colour, dimmed colour and blink period of each condition
  function automatic look_t look(input cond_t c);
    look_t l;
    case (c)
      COND_NET_DOWN:    l = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, DIM_255, 10'd600};
      COND_WAITING:     l = '{8'd255, 8'd200, 8'd0, DIM_255, DIM_200, 8'd0, 10'd125};
      COND_LINKED:      l = '{8'd0, 8'd255, 8'd0, 8'd0, DIM_255, 8'd0, 10'd0};
      COND_STANDALONE:  l = '{8'd0, 8'd120, 8'd0, 8'd0, DIM_120, 8'd0, 10'd0};
      COND_SERVER_DOWN: l = '{8'd255, 8'd0, 8'd255, DIM_255, 8'd0, DIM_255, 10'd400};
      default:          l = '0;
    endcase
    return l;
  endfunction

endpackage

@@ src/slbc_ifs.sv @@
// input channel: one update tick per transaction
interface slbc_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] time_ms;
  logic        network_up;
  logic        server_ok;
  logic [31:0] last_packet_ms;

  modport source (output valid, time_ms, network_up, server_ok, last_packet_ms,
                  input ready);
  modport sink (input valid, time_ms, network_up, server_ok, last_packet_ms,
                output ready);
endinterface

// result channel: one pixel colour and condition per transaction
interface slbc_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [2:0] condition;

  modport source (output valid, red, green, blue, condition, input ready);
  modport sink (input valid, red, green, blue, condition, output ready);
endinterface

@@ src/slbc_decide.sv @@
module slbc_decide (
  input  slbc_pkg::in_item_t     item,
  input  slbc_pkg::cfg_t         cfg,
  input  slbc_pkg::blink_state_t st,
  output slbc_pkg::out_item_t    res,
  output slbc_pkg::blink_state_t st_nxt
);

  slbc_pkg::cond_t cond;
  slbc_pkg::look_t lk;
  logic [31:0]     pkt_age;
  logic [31:0]     flip_age;
  logic            alive;
  logic            blinking;
  logic            show;
  logic [7:0]      r_sel;
  logic [7:0]      g_sel;
  logic [7:0]      b_sel;

  // link alive test with wrapping age
  assign pkt_age = item.time_ms - item.last_packet_ms;
  assign alive   = (item.last_packet_ms != 32'd0) && (pkt_age < cfg.alive_window_ms);

  // condition priority
  always_comb begin
    if (!item.network_up) begin
      cond = slbc_pkg::COND_NET_DOWN;
    end else if (!item.server_ok) begin
      cond = slbc_pkg::COND_SERVER_DOWN;
    end else if (cfg.standalone_role) begin
      cond = slbc_pkg::COND_STANDALONE;
    end else if (alive) begin
      cond = slbc_pkg::COND_LINKED;
    end else begin
      cond = slbc_pkg::COND_WAITING;
    end
  end

  assign lk       = slbc_pkg::look(cond);
  assign blinking = (lk.period != '0);
  assign flip_age = item.time_ms - st.last_flip_ms;

  // blink timer
  always_comb begin
    st_nxt = st;
    if (blinking && (flip_age >= {{(32 - slbc_pkg::PERIOD_W){1'b0}}, lk.period})) begin
      st_nxt.last_flip_ms = item.time_ms;
      st_nxt.blink_phase  = ~st.blink_phase;
    end
  end

  assign show = !blinking || st_nxt.blink_phase;

  // brightness selection
  always_comb begin
    case (cfg.brightness_mode)
      slbc_pkg::MODE_DIM: begin
        r_sel = lk.dr;
        g_sel = lk.dg;
        b_sel = lk.db;
      end
      slbc_pkg::MODE_OFF: begin
        r_sel = 8'd0;
        g_sel = 8'd0;
        b_sel = 8'd0;
      end
      default: begin
        r_sel = lk.r;
        g_sel = lk.g;
        b_sel = lk.b;
      end
    endcase
  end

  assign res.red       = show ? r_sel : 8'd0;
  assign res.green     = show ? g_sel : 8'd0;
  assign res.blue      = show ? b_sel : 8'd0;
  assign res.condition = cond;

endmodule

@@ src/status_led_blink_controller_unit.sv @@
// Status pixel blink controller.
// in_s carries one update tick per transaction (time, network and server
// flags, time of the last scanner packet); out_m returns one transaction per
// tick with the pixel colour and the chosen condition, in order.
// The APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds
// brightness_mode at 0x0, standalone_role at 0x4 and alive_window_ms at 0x8;
// pready is always high and writes land at the access cycle. Write registers
// only while no tick is in flight.
// An accepted tick is offered on out_m once it has reached the output register.
// Throughput: one tick per cycle while out_m does not stall. The tick sits in
// an input register, the condition, blink timer and colour are worked out in
// one combinational pass, and the result is held in an output register.
// When out_m stalls the output register holds its result, the input register
// still takes one more tick, and in_s.ready drops only when both are full.
// Reset (rst_n low, synchronous) empties both registers, clears the blink
// timer to time 0 in the light-off phase and loads the register defaults.
module status_led_blink_controller_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  slbc_in_if.sink                       in_s,
  slbc_out_if.source                    out_m,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slbc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  slbc_pkg::cfg_t         cfg_r;
  slbc_pkg::blink_state_t st_r;
  slbc_pkg::blink_state_t st_nxt;
  slbc_pkg::in_item_t     s1_item_r;
  slbc_pkg::out_item_t    out_item_r;
  slbc_pkg::out_item_t    res;
  logic                   s1_valid_r;
  logic                   out_valid_r;
  logic                   advance;
  logic                   in_ready;
  logic                   cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness_mode <= slbc_pkg::MODE_NORMAL;
      cfg_r.standalone_role <= 1'b0;
      cfg_r.alive_window_ms <= slbc_pkg::ALIVE_RESET;
    end else if (cfg_wr) begin
      case (paddr)
        slbc_pkg::ADDR_BRIGHTNESS: cfg_r.brightness_mode <= pwdata[1:0];
        slbc_pkg::ADDR_STANDALONE: cfg_r.standalone_role <= pwdata[0];
        slbc_pkg::ADDR_ALIVE:      cfg_r.alive_window_ms <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr)
      slbc_pkg::ADDR_BRIGHTNESS: prdata = {30'd0, cfg_r.brightness_mode};
      slbc_pkg::ADDR_STANDALONE: prdata = {31'd0, cfg_r.standalone_role};
      slbc_pkg::ADDR_ALIVE:      prdata = cfg_r.alive_window_ms;
      default:                   prdata = 32'd0;
    endcase
  end

  // handshake control
  assign advance       = s1_valid_r && (!out_valid_r || out_m.ready);
  assign in_ready      = !s1_valid_r || advance;
  assign in_s.ready    = in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_ready) begin
      s1_item_r.time_ms        <= in_s.time_ms;
      s1_item_r.network_up     <= in_s.network_up;
      s1_item_r.server_ok      <= in_s.server_ok;
      s1_item_r.last_packet_ms <= in_s.last_packet_ms;
    end
  end

  // condition, blink and colour
  slbc_decide u_decide (
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .res    (res),
    .st_nxt (st_nxt)
  );

  // blink state, updated once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_m.valid     = out_valid_r;
  assign out_m.red       = out_item_r.red;
  assign out_m.green     = out_item_r.green;
  assign out_m.blue      = out_item_r.blue;
  assign out_m.condition = out_item_r.condition;

  // a phase flip always restarts the timer at a new time
  a_flip_moves_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.blink_phase != $past(st_r.blink_phase)) |->
    (st_r.last_flip_ms != $past(st_r.last_flip_ms)))
    else $error("blink phase flipped without timer restart");

  // blink state only moves when a tick is processed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> (st_r == $past(st_r)))
    else $error("blink state changed without a tick");

  // a processed tick always lands in the output register
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed tick lost");

endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 300;
  localparam int SEG_ITEMS      = 235;

  logic clk;
  logic rst_n;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  wire  [31:0]        prdata;
  wire                pready;

  slbc_in_if  in_if (clk);
  slbc_out_if out_if (clk);

  status_led_blink_controller_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_if),
    .out_m   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the block's registers and blink timer
  logic [1:0]  cfg_mode   = MODE_NORMAL;
  logic        cfg_role   = 1'b0;
  logic [31:0] cfg_window = ALIVE_RESET;
  logic [31:0] flip_ms    = '0;
  logic        phase_on   = 1'b0;

  // pixels still owed by the block, oldest first
  out_item_t pixel_q[$];
  int        mismatch_cnt = 0;

  // traffic shaping knobs
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          rx_hold_req = 0;
  int          rx_hold_left = 0;
  logic [31:0] clock_ms = '0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // palette level after the brightness mode
  function automatic logic [7:0] shade_level(logic [7:0] x);
    int unsigned v;
    case (cfg_mode)
      MODE_OFF: v = 0;
      MODE_DIM: v = (int'(x) * DIM_NUM) / DIM_DEN;
      default:  v = 32'(x);
    endcase
    return v[7:0];
  endfunction

  // expected pixel for one tick; advances the shadow blink timer
  function automatic out_item_t predict_pixel(in_item_t t);
    out_item_t   p;
    cond_t       c;
    logic [7:0]  r, g, b;
    logic [31:0] period;
    logic [31:0] age;
    logic        lit;
    age = t.time_ms - t.last_packet_ms;
    if (!t.network_up) c = COND_NET_DOWN;
    else if (!t.server_ok) c = COND_SERVER_DOWN;
    else if (cfg_role) c = COND_STANDALONE;
    else if (t.last_packet_ms != 32'd0 && age < cfg_window) c = COND_LINKED;
    else c = COND_WAITING;
    case (c)
      COND_NET_DOWN: begin
        r = 8'd0; g = 8'd0; b = 8'd255; period = 32'd600;
      end
      COND_WAITING: begin
        r = 8'd255; g = 8'd200; b = 8'd0; period = 32'd125;
      end
      COND_LINKED: begin
        r = 8'd0; g = 8'd255; b = 8'd0; period = 32'd0;
      end
      COND_STANDALONE: begin
        r = 8'd0; g = 8'd120; b = 8'd0; period = 32'd0;
      end
      default: begin
        r = 8'd255; g = 8'd0; b = 8'd255; period = 32'd400;
      end
    endcase
    if (period == 32'd0) begin
      lit = 1'b1;
    end else begin
      age = t.time_ms - flip_ms;
      if (age >= period) begin
        flip_ms  = t.time_ms;
        phase_on = ~phase_on;
      end
      lit = phase_on;
    end
    p.red       = lit ? shade_level(r) : 8'd0;
    p.green     = lit ? shade_level(g) : 8'd0;
    p.blue      = lit ? shade_level(b) : 8'd0;
    p.condition = c;
    return p;
  endfunction

  // offer one tick, wait for its transaction, record the expected pixel
  task automatic send_tick(logic [31:0] now, logic net, logic srv, logic [31:0] pkt);
    in_item_t t;
    t.time_ms        = now;
    t.network_up     = net;
    t.server_ok      = srv;
    t.last_packet_ms = pkt;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_if.valid          <= 1'b1;
    in_if.time_ms        <= now;
    in_if.network_up     <= net;
    in_if.server_ok      <= srv;
    in_if.last_packet_ms <= pkt;
    do @(posedge clk); while (!in_if.ready);
    pixel_q.push_back(predict_pixel(t));
  endtask

  // stop offering and wait until every owed pixel has come back
  task automatic drain_pixels();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pixel_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // one apb write; psel/penable are left high for a following write
  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // write all three registers while the block is idle
  task automatic set_config(logic [31:0] mode_word, logic [31:0] role_word,
                            logic [31:0] window);
    drain_pixels();
    apb_write(ADDR_BRIGHTNESS, mode_word);
    apb_write(ADDR_STANDALONE, role_word);
    apb_write(ADDR_ALIVE, window);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_mode   = mode_word[1:0];
    cfg_role   = role_word[0];
    cfg_window = window;
    @(posedge clk);
  endtask

  // random tick: mostly a running clock with plausible packet times, some noise
  task automatic send_random_tick();
    logic [31:0] now, pkt;
    logic        net, srv;
    if ($urandom_range(0, 99) < 88) begin
      clock_ms += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 800) : $urandom_range(0, 150);
      now = clock_ms;
      net = ($urandom_range(0, 99) < 85);
      srv = ($urandom_range(0, 99) < 85);
      case ($urandom_range(0, 5))
        0:       pkt = 32'd0;
        1, 2:    pkt = now - $urandom_range(0, 4000);
        3:       pkt = now - (cfg_window + $urandom_range(0, 2) - 1);
        4:       pkt = now - $urandom_range(0, 200);
        default: pkt = $urandom;
      endcase
    end else begin
      now = $urandom;
      net = 1'($urandom_range(0, 1));
      srv = 1'($urandom_range(0, 1));
      pkt = $urandom;
    end
    send_tick(now, net, srv, pkt);
  endtask

  // conditions, priority, blink edges and wrap after reset, default registers
  task automatic test_conditions_and_blink();
    send_tick(32'd0, 1'b0, 1'b1, 32'd0);
    send_tick(32'd599, 1'b0, 1'b1, 32'd0);
    send_tick(32'd600, 1'b0, 1'b1, 32'd0);
    send_tick(32'd1000, 1'b1, 1'b0, 32'd0);
    send_tick(32'd1400, 1'b1, 1'b0, 32'd0);
    send_tick(32'd1500, 1'b1, 1'b1, 32'd0);
    send_tick(32'd1525, 1'b1, 1'b1, 32'd0);
    send_tick(32'd2000, 1'b1, 1'b1, 32'd1999);
    // window boundary: exactly the window is no longer alive
    send_tick(32'd4999, 1'b1, 1'b1, 32'd1999);
    send_tick(32'd4998, 1'b1, 1'b1, 32'd1999);
    // packet age wrapping across zero
    send_tick(32'd5, 1'b1, 1'b1, 32'hFFFF_FFF0);
    send_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_tick(32'hFFFF_FFFF, 1'b0, 1'b0, 32'hFFFF_FFFF);
    // blink timer wrapping across zero
    send_tick(32'd3, 1'b0, 1'b0, 32'd0);
    send_tick(32'd600, 1'b0, 1'b1, 32'd0);
  endtask

  // dimming, off and the unused mode, each with steady and blinking colours
  task automatic test_brightness_modes();
    logic [1:0] m;
    for (int i = 1; i <= 3; i++) begin
      m = 2'(i);
      set_config({30'h0, m}, 32'd0, ALIVE_RESET);
      send_tick(32'd10000 + 1000 * i, 1'b1, 1'b1, 32'd9999 + 1000 * i);
      send_tick(32'd10200 + 1000 * i, 1'b1, 1'b1, 32'd0);
      send_tick(32'd10800 + 1000 * i, 1'b0, 1'b1, 32'd0);
    end
  endtask

  // standalone role and the extreme alive windows
  task automatic test_role_and_window();
    set_config({30'h0, MODE_DIM}, 32'd1, ALIVE_RESET);
    send_tick(32'd20000, 1'b1, 1'b1, 32'd19999);
    send_tick(32'd20100, 1'b1, 1'b0, 32'd19999);
    set_config(32'hFFFF_FFFC, 32'hFFFF_FFFE, 32'd0);
    send_tick(32'd21000, 1'b1, 1'b1, 32'd21000);
    set_config(32'd0, 32'd0, 32'hFFFF_FFFF);
    send_tick(32'd22000, 1'b1, 1'b1, 32'd22001);
    send_tick(32'd22000, 1'b1, 1'b1, 32'd22000 + 32'd1);
    send_tick(32'hFFFF_FFFE, 1'b1, 1'b1, 32'hFFFF_FFFF);
  endtask

  // random traffic over four idling phases and two register settings each
  task automatic test_random_traffic();
    int          seg;
    logic [31:0] window;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int k = 0; k < 2; k++) begin
        seg = 2 * ph + k;
        case ($urandom_range(0, 4))
          0:       window = 32'd0;
          1:       window = ALIVE_RESET;
          2:       window = $urandom_range(1, 6000);
          3:       window = 32'hFFFF_FFFF;
          default: window = $urandom;
        endcase
        set_config({$urandom_range(0, 1) ? 30'($urandom) : 30'h0, 2'(seg % 4)},
                   ($urandom_range(0, 3) == 0) ? 32'd1 : 32'd0, window);
        clock_ms = $urandom_range(0, 1) ? 32'hFFFF_F000 + $urandom_range(0, 4000)
                                        : $urandom_range(0, 100000);
        for (int n = 0; n < SEG_ITEMS; n++) send_random_tick();
      end
    end
  endtask

  // receiver holds off for a long stretch while ticks keep coming
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 20;
    rx_hold_req    = 1;
    in_if.valid   <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 40; n++) send_random_tick();
  endtask

  // sender pauses until every pixel is back, then resumes
  task automatic test_sender_pause();
    send_idle_pct  = 10;
    recv_stall_pct = 30;
    for (int n = 0; n < 20; n++) send_random_tick();
    drain_pixels();
    for (int n = 0; n < 20; n++) send_random_tick();
  endtask

  // receiver: checks every pixel transaction and drives ready
  initial begin
    out_item_t want;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pixel_q.size() == 0) begin
          $error("pixel with no tick waiting: r=%0d g=%0d b=%0d cond=%0d",
                 out_if.red, out_if.green, out_if.blue, out_if.condition);
          mismatch_cnt++;
        end else begin
          want = pixel_q.pop_front();
          if (out_if.red !== want.red) begin
            $error("red expected %0d actual %0d", want.red, out_if.red);
            mismatch_cnt++;
          end
          if (out_if.green !== want.green) begin
            $error("green expected %0d actual %0d", want.green, out_if.green);
            mismatch_cnt++;
          end
          if (out_if.blue !== want.blue) begin
            $error("blue expected %0d actual %0d", want.blue, out_if.blue);
            mismatch_cnt++;
          end
          if (out_if.condition !== 3'(want.condition)) begin
            $error("condition expected %0d actual %0d", want.condition, out_if.condition);
            mismatch_cnt++;
          end
        end
      end
      if (rx_hold_req) begin
        rx_hold_req  = 0;
        rx_hold_left = LONG_HOLD;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.time_ms        <= '0;
    in_if.network_up     <= 1'b0;
    in_if.server_ok      <= 1'b0;
    in_if.last_packet_ms <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_conditions_and_blink();
    test_brightness_modes();
    test_role_and_window();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pause();

    drain_pixels();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/slbc_pkg.sv
src/slbc_ifs.sv
src/slbc_decide.sv
src/status_led_blink_controller_unit.sv
bench/tb.sv
